// ----- design/crc_checked_command_frame_receiver_unit_macros.svh -----
// Assertion macros for the command frame receiver.
// Used by the top level only; no other dependencies.
`ifndef CRC_CHECKED_COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CRC_CHECKED_COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CRCFR_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("frame receiver check failed");

// Next-cycle implication, disabled in reset.
`define CRCFR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("frame receiver check failed");

`endif

// ----- design/crcfr_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// No dependencies; the front, queue, back and top level import it.
`default_nettype none

package crcfr_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int CRC_BYTES   = FRAME_BYTES - 2;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [15:0] YAW_DB_LOW_RESET  = 16'd1485;
   localparam logic [15:0] YAW_DB_HIGH_RESET = 16'd1515;
   localparam logic [15:0] RUN_THR_RESET     = 16'd1030;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_DB_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_DB_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_THR     = 2'd2;

   // drive mode codes
   localparam logic [1:0] DRIVE_OFF  = 2'd0;
   localparam logic [1:0] DRIVE_IDLE = 2'd1;
   localparam logic [1:0] DRIVE_RUN  = 2'd2;

   typedef struct packed {
      logic [15:0] yaw_db_low;
      logic [15:0] yaw_db_high;
      logic [15:0] run_thr;
   } cfg_type;

   // Parsed record, bytes 2 to 29 of a frame
   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] throttle;
      logic [15:0] yaw;
      logic [31:0] roll_gain;
      logic [31:0] pitch_gain;
      logic [31:0] yaw_rate_gain;
      logic [31:0] yaw_heading_gain;
      logic [7:0]  failsafe_byte;
      logic [7:0]  arming_byte;
      logic [15:0] aux;
   } frame_rec_type;

   typedef struct packed {
      logic          ok;
      frame_rec_type rec;
   } frame_report_type;

   typedef struct packed {
      logic             valid;
      frame_report_type frame;
   } queue_port_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- design/crcfr_channels.sv -----
// Handshake channels of the frame receiver: request bytes and result records.
// No dependencies.
`default_nettype none

interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_last;

   modport source (output valid, data_byte, frame_last, input ready);
   modport sink   (input valid, data_byte, frame_last, output ready);
endinterface

interface crcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] roll_setpoint;
   logic [15:0] pitch_setpoint;
   logic [15:0] throttle_setpoint;
   logic [15:0] yaw_setpoint;
   logic [31:0] roll_gain_word;
   logic [31:0] pitch_gain_word;
   logic [31:0] yaw_gain_word;
   logic        failsafe_active;
   logic        armed;
   logic [15:0] aux_word;
   logic [1:0]  drive_mode;
   logic        frame_ok;

   modport source (output valid, roll_setpoint, pitch_setpoint, throttle_setpoint,
                   yaw_setpoint, roll_gain_word, pitch_gain_word, yaw_gain_word,
                   failsafe_active, armed, aux_word, drive_mode, frame_ok,
                   input ready);
   modport sink   (input valid, roll_setpoint, pitch_setpoint, throttle_setpoint,
                   yaw_setpoint, roll_gain_word, pitch_gain_word, yaw_gain_word,
                   failsafe_active, armed, aux_word, drive_mode, frame_ok,
                   output ready);
endinterface

`default_nettype wire

// ----- design/crcfr_front.sv -----
// Front end: takes frame bytes, stages them, runs the CRC and reports each frame end.
// Depends on crcfr_pkg and crcfr_channels.
`default_nettype none

module crcfr_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   crcfr_req_if.sink                 req_chan,
   input  wire logic                 push_ready,
   output crcfr_pkg::queue_port_type push
);
   import crcfr_pkg::*;

   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       staging_ff [FRAME_BYTES];
   logic             accept;
   logic             frame_ok;
   frame_rec_type    rec;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign frame_ok = !ovf_ff && (pos_ff == POS_W'(FRAME_BYTES - 1)) && req_chan.frame_last &&
                     (staging_ff[CRC_BYTES] == crc_ff[7:0]) &&
                     (req_chan.data_byte == crc_ff[15:8]);

   always_comb begin
      rec.roll             = {staging_ff[3], staging_ff[2]};
      rec.pitch            = {staging_ff[5], staging_ff[4]};
      rec.throttle         = {staging_ff[7], staging_ff[6]};
      rec.yaw              = {staging_ff[9], staging_ff[8]};
      rec.roll_gain        = {staging_ff[13], staging_ff[12], staging_ff[11], staging_ff[10]};
      rec.pitch_gain       = {staging_ff[17], staging_ff[16], staging_ff[15], staging_ff[14]};
      rec.yaw_rate_gain    = {staging_ff[21], staging_ff[20], staging_ff[19], staging_ff[18]};
      rec.yaw_heading_gain = {staging_ff[25], staging_ff[24], staging_ff[23], staging_ff[22]};
      rec.failsafe_byte    = staging_ff[26];
      rec.arming_byte      = staging_ff[27];
      rec.aux              = {staging_ff[29], staging_ff[28]};
   end

   always_comb begin
      push.valid     = accept && req_chan.frame_last;
      push.frame.ok  = frame_ok;
      push.frame.rec = rec;
   end

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_chan.frame_last) begin
            crc_in = CRC_INIT;
            pos_in = '0;
            ovf_in = 1'b0;
         end else if (!ovf_ff) begin
            if (pos_ff < POS_W'(CRC_BYTES)) begin
               crc_in = crc16_byte(crc_ff, req_chan.data_byte);
            end
            pos_in = pos_ff + POS_W'(1);
            // past the last slot: drop further bytes until frame end
            if (pos_ff == POS_W'(FRAME_BYTES - 1)) begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         pos_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !ovf_ff) begin
         staging_ff[pos_ff] <= req_chan.data_byte;
      end
   end

endmodule

`default_nettype wire

// ----- design/crcfr_queue.sv -----
// Short queue of frame reports between front and back end.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crcfr_pkg::queue_port_type push,
   output logic                      push_ready,
   output crcfr_pkg::queue_port_type pop,
   input  wire logic                 pop_ready
);
   import crcfr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_report_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.frame  = entries_ff[rd_ptr_ff];

   assign do_push = push.valid && push_ready;
   assign do_pop  = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

`default_nettype wire

// ----- design/crcfr_back.sv -----
// Back end: keeps the held record, picks the yaw word and drive mode, drives results.
// Depends on crcfr_pkg and crcfr_channels.
`default_nettype none

module crcfr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crcfr_pkg::cfg_type   cfg,
   input  wire crcfr_pkg::queue_port_type pop,
   output logic                      pop_ready,
   crcfr_rsp_if.source               rsp_chan
);
   import crcfr_pkg::*;

   frame_rec_type held_ff, held_in;
   logic          out_valid_ff, out_valid_in;
   frame_rec_type out_rec_ff;
   logic [31:0]   out_yaw_word_ff, yaw_word_in;
   logic [1:0]    out_mode_ff, mode_in;
   logic          out_ok_ff;
   logic          out_fs_ff, out_arm_ff;
   logic          fs_in, arm_in;
   logic          do_pop;

   assign pop_ready = !out_valid_ff || rsp_chan.ready;
   assign do_pop    = pop.valid && pop_ready;

   always_comb begin
      held_in = (pop.frame.ok) ? pop.frame.rec : held_ff;
      fs_in   = (held_in.failsafe_byte != 8'd0);
      arm_in  = (held_in.arming_byte == 8'd1);
      yaw_word_in = (held_in.yaw < cfg.yaw_db_low || held_in.yaw > cfg.yaw_db_high) ?
                    held_in.yaw_rate_gain : held_in.yaw_heading_gain;
      if (arm_in && !fs_in) begin
         mode_in = (held_in.throttle > cfg.run_thr) ? DRIVE_RUN : DRIVE_IDLE;
      end else begin
         mode_in = DRIVE_OFF;
      end
      out_valid_in = do_pop || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (do_pop) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         out_rec_ff      <= held_in;
         out_yaw_word_ff <= yaw_word_in;
         out_mode_ff     <= mode_in;
         out_ok_ff       <= pop.frame.ok;
         out_fs_ff       <= fs_in;
         out_arm_ff      <= arm_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.roll_setpoint     = out_rec_ff.roll;
   assign rsp_chan.pitch_setpoint    = out_rec_ff.pitch;
   assign rsp_chan.throttle_setpoint = out_rec_ff.throttle;
   assign rsp_chan.yaw_setpoint      = out_rec_ff.yaw;
   assign rsp_chan.roll_gain_word    = out_rec_ff.roll_gain;
   assign rsp_chan.pitch_gain_word   = out_rec_ff.pitch_gain;
   assign rsp_chan.yaw_gain_word     = out_yaw_word_ff;
   assign rsp_chan.failsafe_active   = out_fs_ff;
   assign rsp_chan.armed             = out_arm_ff;
   assign rsp_chan.aux_word          = out_rec_ff.aux;
   assign rsp_chan.drive_mode        = out_mode_ff;
   assign rsp_chan.frame_ok          = out_ok_ff;

endmodule

`default_nettype wire

// ----- design/crc_checked_command_frame_receiver_unit.sv -----
// Top level of the CRC-checked command frame receiver: CSRs, front, queue, back.
// Depends on crcfr_pkg, crcfr_channels, crcfr_front, crcfr_queue, crcfr_back and the macros.
`default_nettype none
`include "crc_checked_command_frame_receiver_unit_macros.svh"

// Receives 32-byte command frames one word (byte) per cycle on req_chan and
// checks a CRC-16 (poly 0x1021, init 0xFFFF, MSB first, no final xor) over
// bytes 0 to 29 against byte 30 (CRC low) and byte 31 (CRC high). A frame is
// good only if frame_last comes with its 32nd byte and the CRC matches; a
// good frame replaces the held record (little-endian setpoints, gain words,
// flag and aux bytes), a bad one leaves it alone. Every frame end, good or
// bad, produces one result word on rsp_chan carrying the held record, the
// yaw word picked by the deadband CSRs, a drive mode (off, idle, run) and
// frame_ok. Bytes past the 32nd are dropped until frame_last. Rate: one
// byte per cycle, sustained, including back-to-back frame ends; req ready
// falls only when the two-entry report queue between the byte front end and
// the record back end is full, which happens only while rsp ready is held
// low. The report of the last byte is written into the queue entry register
// and is then loaded from the queue head into the output register driving
// rsp_chan, so the result word is registered. CSRs: index 0 yaw deadband low
// (1485), 1 yaw deadband high (1515), 2 run throttle threshold (1030); write
// them only while no frame report is in flight.
module crc_checked_command_frame_receiver_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   crcfr_req_if.sink                                 req_chan,
   crcfr_rsp_if.source                               rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [crcfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [crcfr_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import crcfr_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_port_type push;
   queue_port_type pop;
   logic           push_ready;
   logic           pop_ready;

   // CSR write decode; an index past the list is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_YAW_DB_LOW:  cfg_in.yaw_db_low  = csr_write_data;
            CSR_YAW_DB_HIGH: cfg_in.yaw_db_high = csr_write_data;
            CSR_RUN_THR:     cfg_in.run_thr     = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_db_low  <= YAW_DB_LOW_RESET;
         cfg_ff.yaw_db_high <= YAW_DB_HIGH_RESET;
         cfg_ff.run_thr     <= RUN_THR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: stage bytes, run the CRC, push one report per frame end
   crcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push       (push)
   );

   // Queue: decouple byte intake from result stalls
   crcfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   // Back: update the held record and drive the result register
   crcfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

   // A full queue must hold off the byte side
   `CRCFR_ASSERT_IMPLIES(a_full_blocks_req, clock, reset, !push_ready, !req_chan.ready)
   // Pop only into a free or draining output register
   `CRCFR_ASSERT_IMPLIES(a_pop_into_free_slot, clock, reset, pop.valid && pop_ready,
                         !rsp_chan.valid || rsp_chan.ready)
   // Run mode only for an armed record without failsafe
   `CRCFR_ASSERT_IMPLIES(a_run_needs_armed, clock, reset,
                         rsp_chan.valid && rsp_chan.drive_mode == DRIVE_RUN,
                         rsp_chan.armed && !rsp_chan.failsafe_active)
   // A popped report shows up as a result on the next cycle
   `CRCFR_ASSERT_NEXT(a_pop_gives_result, clock, reset, pop.valid && pop_ready,
                      rsp_chan.valid)

endmodule

`default_nettype wire
